// ===== hdl/pnp_pkg.sv =====
package pnp_pkg;

  // Default data format: signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Newton step count register
  localparam int              ITER_W     = 6;
  localparam logic [ITER_W-1:0] ITER_RESET = 6'd20;

endpackage

// ===== hdl/pnp_chan_if.sv =====
// Input request channel: one (theta, momentum) pair
interface pnp_in_if import pnp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] theta_in;
  logic signed [DATA_WIDTH-1:0] momentum_in;

  modport source (output valid, output theta_in, output momentum_in, input ready);
  modport sink   (input valid, input theta_in, input momentum_in, output ready);
endinterface

// Result channel: projected pair and feasible flag
interface pnp_out_if import pnp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] theta_out;
  logic signed [DATA_WIDTH-1:0] momentum_out;
  logic                         was_feasible;

  modport source (output valid, output theta_out, output momentum_out,
                  output was_feasible, input ready);
  modport sink   (input valid, input theta_out, input momentum_out,
                  input was_feasible, output ready);
endinterface

// Configuration write channel: step count register
interface pnp_cfg_if import pnp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

// ===== hdl/pnp_mul.sv =====
// Unsigned magnitude multiplier, two half-width partial products accumulated low half first
module pnp_mul import pnp_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DATA_WIDTH-1:0]     a,
  input  logic [DATA_WIDTH-1:0]     b,
  output logic                      done,
  output logic [2*DATA_WIDTH-1:0]   prod
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int H  = (DW + 1) / 2;
  localparam int HB = DW - H;

  logic [DW-1:0]    a_r;
  logic [HB-1:0]    bh_r;
  logic [PW-1:0]    acc_r;
  logic             busy_r;
  logic             done_r;
  logic [DW+H-1:0]  plo;
  logic [DW+HB-1:0] phi;

  // Low and high partial products
  assign plo = a * b[H-1:0];
  assign phi = a_r * bh_r;

  // Accumulate low half first, then the shifted high half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        bh_r   <= b[DW-1:H];
        acc_r  <= PW'(plo);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + (PW'(phi) << H);
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hdl/pnp_div.sv =====
// Signed fixed-point divider, restoring, one quotient bit per cycle.
// Quotient is truncated toward zero and saturated to the data range.
module pnp_div import pnp_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic signed [DATA_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quo
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = (FRAC_BITS + 1 > DW) ? FRAC_BITS + 1 : DW;
  localparam int CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DW - 1);
  localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_SIGN} div_state_t;

  div_state_t       state_r;
  logic [DW-1:0]    dm_r;
  logic [DW-1:0]    rem_r;
  logic [DW-2:0]    low_r;
  logic [DW-2:0]    quo_bits_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             done_r;
  logic signed [DW-1:0] quo_r;

  logic [DW-1:0]      nm;
  logic [DW-1:0]      dm;
  logic [NW-1:0]      nsh;
  logic [FRAC_BITS:0] nhi;
  logic               ovf;
  logic [DW-1:0]      r2;
  logic               fits;
  logic [DW-1:0]      qpos;

  // Operand magnitudes and the overflow test on the top numerator bits
  assign nm   = num[DW-1] ? DW'(~num + 1'b1) : DW'(num);
  assign dm   = den[DW-1] ? DW'(~den + 1'b1) : DW'(den);
  assign nsh  = {nm, {FRAC_BITS{1'b0}}};
  assign nhi  = nsh[NW-1:DW-1];
  assign ovf  = CW'(nhi) >= CW'(dm);

  // Trial subtraction for one quotient bit
  assign r2   = {rem_r[DW-2:0], low_r[DW-2]};
  assign fits = r2 >= dm_r;
  assign qpos = {1'b0, quo_bits_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r <= num[DW-1] ^ den[DW-1];
            if (ovf) begin
              quo_r  <= (num[DW-1] ^ den[DW-1]) ? QMIN : QMAX;
              done_r <= 1'b1;
            end else begin
              dm_r       <= dm;
              rem_r      <= DW'(nhi);
              low_r      <= nsh[DW-2:0];
              quo_bits_r <= '0;
              cnt_r      <= STEPS;
              state_r    <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r      <= fits ? r2 - dm_r : r2;
          quo_bits_r <= {quo_bits_r[DW-3:0], fits};
          low_r      <= {low_r[DW-3:0], 1'b0};
          cnt_r      <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= D_SIGN;
        end
        D_SIGN: begin
          quo_r   <= neg_r ? $signed(~qpos + 1'b1) : $signed(qpos);
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/parabola_newton_projection_unit.sv =====
// A pair already inside theta + m^2/4 <= 0 returns once its momentum square is ready.
// Other pairs take N Newton steps, N = iteration_count; each
// Newton step is three passes through the shared multiplier and one
// divide, which ends early when the quotient saturates.
// Throughput: one pair at a time; the next is taken the cycle after the result leaves.
// Reset (synchronous, rst_n low) idles the sequencer and sets iteration_count to 20.
module parabola_newton_projection_unit import pnp_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pnp_in_if.sink    in_req,
  pnp_out_if.source out_rsp,
  pnp_cfg_if.sink   cfg_wr
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int SW = DW + 3;
  localparam int RW = PW + 1 - FRAC_BITS;
  localparam int LW = (PW > DW + FRAC_BITS + 2) ? PW : DW + FRAC_BITS + 2;

  localparam logic signed [SW-1:0] SMAX = {4'b0000, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {4'b1111, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE =
    (FRAC_BITS < DW - 1) ? (DW'(1) << FRAC_BITS) : DMAX;
  localparam logic signed [DW-1:0] TWO =
    (FRAC_BITS + 1 < DW - 1) ? (DW'(2) << FRAC_BITS) : DMAX;
  localparam logic [RW-1:0] HALF_R = RW'(1) << (DW - 1);
  localparam logic [RW-1:0] MAX_R  = HALF_R - 1'b1;
  localparam logic [PW:0]   RND    = (PW+1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FEAS, ST_V2, ST_V3, ST_AV, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  // Saturate a widened signed value to the data range
  function automatic logic signed [DW-1:0] clamp(input logic signed [SW-1:0] x);
    if (x > SMAX) return DMAX;
    if (x < SMIN) return DMIN;
    return x[DW-1:0];
  endfunction

  // Magnitude of a signed value, the most negative one included
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(~x + 1'b1) : DW'(x);
  endfunction

  // Round a magnitude product to nearest, ties away from zero, then saturate
  function automatic logic signed [DW-1:0] mulq(input logic neg, input logic [PW-1:0] p);
    logic [PW:0]   s;
    logic [RW-1:0] m;
    s = {1'b0, p} + RND;
    m = s[PW:FRAC_BITS];
    if (neg) begin
      if (m >= HALF_R) return DMIN;
      return DW'(~m + 1'b1);
    end
    if (m > MAX_R) return DMAX;
    return DW'(m);
  endfunction

  state_t            state_r;
  logic [ITER_W-1:0] iter_cnt_r;
  logic [ITER_W-1:0] k_r;
  logic signed [DW-1:0] theta_r, m_r, a_r, m8_r, v_r, v2_r, t1_r;
  logic signed [DW-1:0] tout_r, mout_r;
  logic              feas_r;
  logic              mul_start_r;
  logic [DW-1:0]     mul_a_r, mul_b_r;
  logic              mul_neg_r;
  logic              div_start_r;
  logic signed [DW-1:0] div_n_r, div_d_r;

  logic              mul_done;
  logic [PW-1:0]     mul_prod;
  logic              div_done;
  logic signed [DW-1:0] div_q;

  logic signed [DW-1:0] mq;
  logic              feasible;
  logic signed [DW-1:0] a_val, m8_val, f_val, df_val, v_new;
  logic [DW:0]       qsq;
  logic [DW-1:0]     qm;
  logic [ITER_W-1:0] k_inc;

  // Shared multiplier and divider
  pnp_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pnp_div #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_n_r),
    .den   (div_d_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // Rounded product of the current multiply
  assign mq = mulq(mul_neg_r, mul_prod);

  // Exact feasibility test on the full square of momentum
  assign feasible = !(theta_r > 0) &&
                    (LW'(mul_prod) <= (LW'(mag(theta_r)) << (FRAC_BITS + 2)));

  // Per-pair constants a = 4(theta+2) and 8m
  assign a_val  = clamp(SW'(clamp(SW'(theta_r) + SW'(TWO))) <<< 2);
  assign m8_val = clamp(SW'(m_r) <<< 3);

  // Newton residual and derivative
  assign f_val  = clamp(SW'(clamp(SW'(t1_r) + SW'(mq))) - SW'(m8_r));
  assign df_val = clamp(SW'(clamp(SW'(v2_r) + (SW'(v2_r) <<< 1))) + SW'(a_r));

  // Update v from the quotient
  assign v_new = clamp(SW'(v_r) - SW'(div_q));
  assign k_inc = k_r + 1'b1;

  // Final theta: -(v^2/4), rounded half up
  assign qsq = ({1'b0, mq} + (DW+1)'(2)) >> 2;
  assign qm  = qsq[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_cnt_r  <= ITER_RESET;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_wr.valid) iter_cnt_r <= cfg_wr.iteration_count;
      unique case (state_r)
        ST_IDLE: begin
          // Take a request and square momentum exactly
          if (in_req.valid) begin
            theta_r     <= in_req.theta_in;
            m_r         <= in_req.momentum_in;
            mul_a_r     <= mag(in_req.momentum_in);
            mul_b_r     <= mag(in_req.momentum_in);
            mul_neg_r   <= 1'b0;
            mul_start_r <= 1'b1;
            state_r     <= ST_FEAS;
          end
        end
        ST_FEAS: begin
          if (mul_done) begin
            if (feasible) begin
              tout_r  <= theta_r;
              mout_r  <= m_r;
              feas_r  <= 1'b1;
              state_r <= ST_OUT;
            end else begin
              a_r         <= a_val;
              m8_r        <= m8_val;
              v_r         <= m_r;
              k_r         <= '0;
              mul_a_r     <= mag(m_r);
              mul_b_r     <= mag(m_r);
              mul_neg_r   <= 1'b0;
              mul_start_r <= 1'b1;
              state_r     <= (iter_cnt_r == '0) ? ST_FIN : ST_V2;
            end
          end
        end
        ST_V2: begin
          // v^2 ready; launch v^2 * v
          if (mul_done) begin
            v2_r        <= mq;
            mul_a_r     <= mag(mq);
            mul_b_r     <= mag(v_r);
            mul_neg_r   <= mq[DW-1] ^ v_r[DW-1];
            mul_start_r <= 1'b1;
            state_r     <= ST_V3;
          end
        end
        ST_V3: begin
          // v^3 ready; launch a * v
          if (mul_done) begin
            t1_r        <= mq;
            mul_a_r     <= mag(a_r);
            mul_b_r     <= mag(v_r);
            mul_neg_r   <= a_r[DW-1] ^ v_r[DW-1];
            mul_start_r <= 1'b1;
            state_r     <= ST_AV;
          end
        end
        ST_AV: begin
          // Residual and derivative ready; divide, with a unit divisor at zero slope
          if (mul_done) begin
            div_n_r     <= f_val;
            div_d_r     <= (df_val == '0) ? ONE : df_val;
            div_start_r <= 1'b1;
            state_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Advance v and square it for the next step or the final result
          if (div_done) begin
            v_r         <= v_new;
            k_r         <= k_inc;
            mul_a_r     <= mag(v_new);
            mul_b_r     <= mag(v_new);
            mul_neg_r   <= 1'b0;
            mul_start_r <= 1'b1;
            state_r     <= (k_inc == iter_cnt_r) ? ST_FIN : ST_V2;
          end
        end
        ST_FIN: begin
          if (mul_done) begin
            tout_r  <= $signed(~qm + 1'b1);
            mout_r  <= v_r;
            feas_r  <= 1'b0;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the result until it is taken
          if (out_rsp.ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_req.ready         = (state_r == ST_IDLE);
  assign cfg_wr.ready         = 1'b1;
  assign out_rsp.valid        = (state_r == ST_OUT);
  assign out_rsp.theta_out    = tout_r;
  assign out_rsp.momentum_out = mout_r;
  assign out_rsp.was_feasible = feas_r;

endmodule
